>>> sv/pem_pkg.sv
// Shared types, constants and handshake structs for the pulse energy meter.
package pem_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int TS_W      = 32;
    localparam int CNT_W     = 32;
    localparam int SUB_W     = 16;
    localparam int PWR_W     = 32;
    localparam int CFG_W     = 16;
    localparam int ETOT_W    = 42;
    localparam int ESUB_W    = 26;
    localparam int SUM_W     = TS_W + 1;
    localparam int DEN_W     = SUM_W + CFG_W;
    localparam int PDIV_W    = DEN_W + 1;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_PPK  = 1'b0;
    localparam logic REG_CORR = 1'b1;

    // Constants
    localparam logic [CFG_W-1:0]  PPK_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0]  CORR_RESET  = 16'd0;
    localparam logic [PDIV_W-1:0] TWO_WS_KWH  = 50'd7200000000;
    localparam logic [9:0]        WH_PER_KWH  = 10'd1000;
    localparam logic [PWR_W-1:0]  PWR_MAX     = 32'd3600000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TS_W-1:0]   timestamp_us;
        logic [CNT_W-1:0]  preset_value;
    } t_in_item;

    typedef struct packed {
        logic [PWR_W-1:0]  power_w;
        logic [CNT_W-1:0]  total_pulses;
        logic [SUB_W-1:0]  subtotal_pulses;
        logic [ETOT_W-1:0] total_energy_wh;
        logic [ESUB_W-1:0] subtotal_energy_wh;
    } t_out_item;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;
        logic mul;
        logic start;
        logic finish;
    } t_ctl_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/pulse_energy_meter.sv
// Pulse energy meter top level: register port, controller and datapath.
// Each transaction runs through accept, multiply, divider load, the divide steps
//   set by the total-energy divider, and output load once the output register is free.
// One item in flight at a time; a new item is accepted only after the last result is loaded.
// Reset: synchronous active-low; counts, timestamp and power clear to zero,
//   pulses_per_kwh to 1000, correction to 0. No clearing pass.
module pulse_energy_meter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pem_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pem_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pem_pkg::APB_AW-1:0]  paddr,
    input  logic [pem_pkg::APB_DW-1:0]  pwdata,
    output logic [pem_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pem_pkg::*;

    logic [CFG_W-1:0] r_ppk;
    logic [CFG_W-1:0] r_corr;
    logic             cfg_wr;
    t_ctl_cmd         cmd;
    t_dp_stat         stat;

    // Register writes
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppk  <= PPK_RESET;
            r_corr <= CORR_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_PPK:  r_ppk  <= pwdata[CFG_W-1:0];
                REG_CORR: r_corr <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    assign prdata = (paddr[2] == REG_CORR) ? APB_DW'(r_corr) : APB_DW'(r_ppk);
    assign pready = 1'b1;

    pem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    pem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_ppk       (r_ppk),
        .i_corr      (r_corr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // One transaction at a time: no accept on back-to-back cycles
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction is in progress");

    // A new result only appears while the block is busy with an item
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result produced without a transaction in progress");

    // Power never exceeds the value for a one-microsecond interval
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.power_w <= PWR_MAX))
        else $error("power estimate out of range");

    // Subtotal energy bounded by subtotal count times 1000
    a_sub_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.subtotal_energy_wh <=
            ({10'd0, o_out_data.subtotal_pulses} * ESUB_W'(WH_PER_KWH))))
        else $error("subtotal energy exceeds count times 1000");
`endif

endmodule

>>> sv/pem_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module pem_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 16,
    parameter int QUO_W = 42
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quotient
);
    localparam int ITER_W = $clog2(QUO_W + 1);

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [DVS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    // Shift in next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(QUO_W);
        end else if (r_busy) begin
            r_iter <= r_iter - 1'b1;
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Caller guarantees the high part of the dividend is below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend >> QUO_W);
            r_quo <= QUO_W'(i_dividend);
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> sv/pem_ctrl.sv
// Sequencing state machine for one transaction at a time.
module pem_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output pem_pkg::t_ctl_cmd o_cmd,
    input  pem_pkg::t_dp_stat i_stat
);
    import pem_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> sv/pem_dp.sv
// Counters, power and energy arithmetic, and the output register.
module pem_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pem_pkg::t_ctl_cmd          i_cmd,
    output pem_pkg::t_dp_stat          o_stat,
    input  pem_pkg::t_in_item          i_in_data,
    input  logic [pem_pkg::CFG_W-1:0]  i_ppk,
    input  logic [pem_pkg::CFG_W-1:0]  i_corr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pem_pkg::t_out_item         o_out_data
);
    import pem_pkg::*;

    logic [CNT_W-1:0] r_total;
    logic [SUB_W-1:0] r_sub;
    logic [TS_W-1:0]  r_prev_ts;
    logic [PWR_W-1:0] r_last_pwr;
    logic             r_pwr_go;
    logic [SUM_W-1:0] r_sum;
    logic [DEN_W-1:0] r_den;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [TS_W-1:0]   interval;
    logic [CFG_W-1:0]  mc;
    logic              busy_pwr;
    logic              busy_tot;
    logic              busy_sub;
    logic [PWR_W-1:0]  q_pwr;
    logic [ETOT_W-1:0] q_tot;
    logic [ESUB_W-1:0] q_sub;
    logic [PWR_W-1:0]  pwr_now;

    // Meter constant of zero acts as one
    assign mc       = (i_ppk == '0) ? CFG_W'(1) : i_ppk;
    assign interval = i_in_data.timestamp_us - r_prev_ts;

    // Count update at transaction accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_sub     <= '0;
            r_prev_ts <= '0;
            r_pwr_go  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_pwr_go <= 1'b0;
            case (i_in_data.kind)
                KIND_PULSE: begin
                    r_total   <= r_total + 1'b1;
                    r_sub     <= r_sub + 1'b1;
                    r_prev_ts <= i_in_data.timestamp_us;
                    r_pwr_go  <= (r_prev_ts != '0) && (interval != '0);
                end
                KIND_PRESET: begin
                    r_total <= i_in_data.preset_value;
                end
                KIND_CLEAR: begin
                    r_sub <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Corrected interval, then denominator
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sum <= {1'b0, interval} + SUM_W'(i_corr);
        end
        if (i_cmd.mul) begin
            r_den <= r_sum * mc;
        end
    end

    // Power: (2*3.6e9 + den) / (2*den), rounds half up
    pem_div #(
        .DVD_W(PDIV_W),
        .DVS_W(PDIV_W),
        .QUO_W(PWR_W)
    ) u_div_pwr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (TWO_WS_KWH + {1'b0, r_den}),
        .i_divisor  ({r_den, 1'b0}),
        .o_busy     (busy_pwr),
        .o_quotient (q_pwr)
    );

    // Total energy in Wh
    pem_div #(
        .DVD_W(ETOT_W),
        .DVS_W(CFG_W),
        .QUO_W(ETOT_W)
    ) u_div_tot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend ({10'd0, r_total} * ETOT_W'(WH_PER_KWH)),
        .i_divisor  (mc),
        .o_busy     (busy_tot),
        .o_quotient (q_tot)
    );

    // Subtotal energy in Wh
    pem_div #(
        .DVD_W(ESUB_W),
        .DVS_W(CFG_W),
        .QUO_W(ESUB_W)
    ) u_div_sub (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend ({10'd0, r_sub} * ESUB_W'(WH_PER_KWH)),
        .i_divisor  (mc),
        .o_busy     (busy_sub),
        .o_quotient (q_sub)
    );

    assign pwr_now = r_pwr_go ? q_pwr : r_last_pwr;

    // Power kept across transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pwr <= '0;
        end else if (i_cmd.finish) begin
            r_last_pwr <= pwr_now;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.power_w            <= pwr_now;
            r_out.total_pulses       <= r_total;
            r_out.subtotal_pulses    <= r_sub;
            r_out.total_energy_wh    <= q_tot;
            r_out.subtotal_energy_wh <= q_sub;
        end
    end

    assign o_stat.div_busy = busy_pwr | busy_tot | busy_sub;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule
